/* src/stg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stg_pkg
// shared types, widths and the unit sine table builder of the tone generator
// ----------------------------------------------------------------------------
package stg_pkg;

  localparam int TABLE_LEN   = 1024;
  localparam int TABLE_BITS  = $clog2(TABLE_LEN);
  localparam int PHASE_BITS  = 32;
  localparam int MAX_SEGMENT = 64;

  localparam int FREQ_W   = 16;
  localparam int LEN_W    = 7;
  localparam int RATE_W   = 18;
  localparam int MAG_W    = 15;
  localparam int SAMPLE_W = 16;
  localparam int ROM_W    = 18;
  localparam int ROM_ABS_W = ROM_W - 1;
  localparam int PROD_W   = ROM_ABS_W + MAG_W;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 2 * SAMPLE_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = RATE_W;

  // long division of freq * 2^PHASE_BITS, one dividend bit per step
  localparam int DIV_STEPS = FREQ_W + PHASE_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
  localparam logic [MAG_W-1:0]  MAG_RESET  = MAG_W'(32767);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE   = 1'b1;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ROUND,
    ST_EMIT
  } state_t;

  typedef logic signed [ROM_W-1:0] rom_tbl_t [TABLE_LEN];

  // taylor series of sin over one quadrant, Q32 turns in, Q30 out
  function automatic logic [63:0] sine_quadrant_q30(input logic [63:0] u);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x = (u * TWO_PI_Q30) >> 32;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    // each term from the one before, divided by (2k)(2k+1), signs alternate
    term = ((term * x2) >> 30) / 64'd6;
    sum = (sum > term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum = (sum > term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum = (sum > term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum = (sum > term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd272;
    sum = sum + term;
    return sum;
  endfunction

  function automatic logic signed [ROM_W-1:0] sine_entry(input int i);
    logic [63:0] u;
    logic [63:0] s;
    logic        neg;
    u = (64'(i) << 32) / TABLE_LEN;
    neg = 1'b0;
    if (u >= 64'h8000_0000) begin
      neg = 1'b1;
      u = u - 64'h8000_0000;
    end
    if (u > 64'h4000_0000) begin
      u = 64'h8000_0000 - u;
    end
    s = (sine_quadrant_q30(u) + 64'h2000) >> 14;
    return neg ? ROM_W'(-s) : ROM_W'(s);
  endfunction

  function automatic rom_tbl_t build_sine_rom();
    rom_tbl_t tbl;
    for (int i = 0; i < TABLE_LEN; i++) begin
      tbl[i] = sine_entry(i);
    end
    return tbl;
  endfunction

endpackage

/* src/sine_tone_segment_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_tone_segment_generator_unit
// phase-continuous table-based sine tone generator, one segment per item
// ----------------------------------------------------------------------------
// Each input item is a tone segment (frequency in Hz, sample count, counts
// above 64 saturate to 64). A tone segment first runs a bit-serial long
// division of freq * 2^32 by the sample rate, one quotient bit per cycle,
// and a rounding step; then one sample is issued per cycle, unless the
// output stalls, into a three-stage path (synchronous sine ROM read,
// magnitude multiply, rounding and sign). A tone segment therefore holds the
// input through division, rounding and emission, a silent segment (frequency
// zero) only while its own samples are being issued into the path. The
// input is taken again while the tail of the last segment still drains.
// Output backpressure stalls the whole sample path. Frequency zero emits
// zeros and clears the phase; the phase otherwise carries over between
// segments. Zero sample rate or magnitude registers act as one. The config
// port is ready only while no segment is being worked on and the sample
// path is empty.
module sine_tone_segment_generator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] tone_frequency, [22:16] segment_length, [23] zero
  input  logic [stg_pkg::IN_DATA_W-1:0]      in_tdata,
  // result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] left_sample, [31:16] right_sample
  output logic [stg_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [stg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // unit sine table, read through a registered port
  localparam stg_pkg::rom_tbl_t SINE_ROM = stg_pkg::build_sine_rom();

  stg_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic [stg_pkg::RATE_W-1:0] rate_r;
  logic [stg_pkg::MAG_W-1:0]  mag_r;
  logic [stg_pkg::RATE_W-1:0] rate_eff;
  logic [stg_pkg::MAG_W-1:0]  mag_eff;

  // segment state
  logic [stg_pkg::PHASE_BITS-1:0] phase_r;
  logic [stg_pkg::PHASE_BITS-1:0] step_r;
  logic [stg_pkg::LEN_W-1:0]      cnt_r;
  logic                           zero_r;

  // divider state
  logic [stg_pkg::FREQ_W-1:0]     num_sh_r;
  logic [stg_pkg::PHASE_BITS-1:0] q_r;
  logic [stg_pkg::RATE_W-1:0]     rem_r;
  logic [stg_pkg::DIV_CNT_W-1:0]  div_cnt_r;

  // sample path
  logic                            s1_v_r, s1_last_r, s1_zero_r;
  logic signed [stg_pkg::ROM_W-1:0] rom_q_r;
  logic                            s2_v_r, s2_last_r, s2_neg_r;
  logic [stg_pkg::PROD_W-1:0]      prod_r;
  logic                            out_tvalid_r, out_tlast_r;
  logic [stg_pkg::SAMPLE_W-1:0]    out_sample_r;

  // control decode
  logic in_accept;
  logic cfg_accept;
  logic advance;
  logic issue;
  logic div_busy;

  // input fields
  logic [stg_pkg::FREQ_W-1:0] in_freq;
  logic [stg_pkg::LEN_W-1:0]  in_len;
  logic [stg_pkg::LEN_W-1:0]  len_sat;

  // divider step
  logic [stg_pkg::RATE_W:0]   trial;
  logic                       trial_ge;
  logic [stg_pkg::RATE_W-1:0] rem_nxt;
  logic                       round_up;

  // sample arithmetic
  logic [stg_pkg::TABLE_BITS-1:0] rom_idx;
  logic [stg_pkg::ROM_W-1:0]      rom_neg;
  logic [stg_pkg::ROM_ABS_W-1:0]  rom_abs;
  logic [stg_pkg::PROD_W-1:0]     prod_nxt;
  logic [stg_pkg::PROD_W-1:0]     prod_rnd;
  logic [stg_pkg::SAMPLE_W-1:0]   mag_rnd;

  assign in_freq = in_tdata[stg_pkg::FREQ_W-1:0];
  assign in_len  = in_tdata[stg_pkg::FREQ_W +: stg_pkg::LEN_W];
  assign len_sat = (in_len > stg_pkg::LEN_W'(stg_pkg::MAX_SEGMENT)) ?
                   stg_pkg::LEN_W'(stg_pkg::MAX_SEGMENT) : in_len;

  // zero registers behave as one
  assign rate_eff = (rate_r == '0) ? stg_pkg::RATE_W'(1) : rate_r;
  assign mag_eff  = (mag_r == '0) ? stg_pkg::MAG_W'(1) : mag_r;

  // whole sample path moves when the output register can take a new item
  assign advance = !out_tvalid_r || out_tready;

  // ------------------------------------------------------------------
  // next state
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stg_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (len_sat == '0) begin
            state_nxt = stg_pkg::ST_IDLE;
          end else if (in_freq == '0) begin
            state_nxt = stg_pkg::ST_EMIT;
          end else begin
            state_nxt = stg_pkg::ST_DIVIDE;
          end
        end
      end
      stg_pkg::ST_DIVIDE: begin
        if (div_cnt_r == '0) begin
          state_nxt = stg_pkg::ST_ROUND;
        end
      end
      stg_pkg::ST_ROUND: begin
        state_nxt = stg_pkg::ST_EMIT;
      end
      stg_pkg::ST_EMIT: begin
        if (advance && cnt_r == stg_pkg::LEN_W'(1)) begin
          state_nxt = stg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stg_pkg::ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // state outputs
  // ------------------------------------------------------------------
  always_comb begin
    in_tready = 1'b0;
    cfg_ready = 1'b0;
    div_busy  = 1'b0;
    issue     = 1'b0;
    unique case (state_r)
      stg_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        // registers change only once every sample has left
        cfg_ready = !s1_v_r && !s2_v_r && !out_tvalid_r;
      end
      stg_pkg::ST_DIVIDE: div_busy = 1'b1;
      stg_pkg::ST_ROUND:  div_busy = 1'b0;
      stg_pkg::ST_EMIT:   issue = advance;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign in_accept  = in_tvalid && in_tready;
  assign cfg_accept = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= stg_pkg::RATE_RESET;
      mag_r  <= stg_pkg::MAG_RESET;
    end else if (cfg_accept) begin
      unique case (cfg_index)
        stg_pkg::CFG_SAMPLE_RATE: rate_r <= cfg_data;
        stg_pkg::CFG_MAGNITUDE:   mag_r  <= cfg_data[stg_pkg::MAG_W-1:0];
        default: rate_r <= rate_r;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // restoring divider step: remainder stays below the rate
  // ------------------------------------------------------------------
  assign trial    = {rem_r, num_sh_r[stg_pkg::FREQ_W-1]};
  assign trial_ge = trial >= {1'b0, rate_eff};
  assign rem_nxt  = trial_ge ? stg_pkg::RATE_W'(trial - {1'b0, rate_eff}) :
                               trial[stg_pkg::RATE_W-1:0];
  // round to nearest: bump when twice the remainder reaches the rate
  assign round_up = {rem_r, 1'b0} >= {1'b0, rate_eff};

  // ------------------------------------------------------------------
  // segment and divider registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      step_r    <= '0;
      cnt_r     <= '0;
      zero_r    <= 1'b0;
      num_sh_r  <= '0;
      q_r       <= '0;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else begin
      if (in_accept) begin
        cnt_r     <= len_sat;
        zero_r    <= (in_freq == '0);
        num_sh_r  <= in_freq;
        q_r       <= '0;
        rem_r     <= '0;
        div_cnt_r <= stg_pkg::DIV_CNT_W'(stg_pkg::DIV_STEPS - 1);
        // silence clears the phase whatever the count
        if (in_freq == '0) begin
          phase_r <= '0;
          step_r  <= '0;
        end
      end
      if (div_busy) begin
        num_sh_r  <= num_sh_r << 1;
        q_r       <= {q_r[stg_pkg::PHASE_BITS-2:0], trial_ge};
        rem_r     <= rem_nxt;
        div_cnt_r <= div_cnt_r - stg_pkg::DIV_CNT_W'(1);
      end
      if (state_r == stg_pkg::ST_ROUND) begin
        step_r <= q_r + stg_pkg::PHASE_BITS'(round_up);
      end
      if (issue) begin
        phase_r <= phase_r + step_r;
        cnt_r   <= cnt_r - stg_pkg::LEN_W'(1);
      end
    end
  end

  // ------------------------------------------------------------------
  // sample path valid bits
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (advance) begin
      s1_v_r       <= issue;
      s2_v_r       <= s1_v_r;
      out_tvalid_r <= s2_v_r;
    end
  end

  // nearest table entry; an index of TABLE_LEN wraps to zero by truncation
  assign rom_idx = phase_r[stg_pkg::PHASE_BITS-1 -: stg_pkg::TABLE_BITS] +
                   stg_pkg::TABLE_BITS'(
                     phase_r[stg_pkg::PHASE_BITS-stg_pkg::TABLE_BITS-1]);

  assign rom_neg  = stg_pkg::ROM_W'(-rom_q_r);
  assign rom_abs  = rom_q_r[stg_pkg::ROM_W-1] ? rom_neg[stg_pkg::ROM_ABS_W-1:0] :
                                               rom_q_r[stg_pkg::ROM_ABS_W-1:0];
  // silent segments force a zero product
  assign prod_nxt = s1_zero_r ? '0 :
                    stg_pkg::PROD_W'(rom_abs) * stg_pkg::PROD_W'(mag_eff);

  // half away from zero: round the magnitude, then apply the sign
  assign prod_rnd = prod_r + stg_pkg::ROUND_HALF;
  assign mag_rnd  = prod_rnd[stg_pkg::PROD_W-1 -: stg_pkg::SAMPLE_W];

  // sample path payload
  always_ff @(posedge clk) begin
    if (advance) begin
      rom_q_r      <= SINE_ROM[rom_idx];
      s1_last_r    <= (cnt_r == stg_pkg::LEN_W'(1));
      s1_zero_r    <= zero_r;
      prod_r       <= prod_nxt;
      s2_last_r    <= s1_last_r;
      s2_neg_r     <= rom_q_r[stg_pkg::ROM_W-1] && !s1_zero_r;
      out_sample_r <= s2_neg_r ? stg_pkg::SAMPLE_W'(-mag_rnd) : mag_rnd;
      out_tlast_r  <= s2_last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = {out_sample_r, out_sample_r};

`ifndef SYNTHESIS
  // the last issue of a segment hands control back to idle
  a_last_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
    issue && cnt_r == stg_pkg::LEN_W'(1) |=> state_r == stg_pkg::ST_IDLE)
    else $error("segment did not end after its last sample");

  // divider remainder never reaches the rate
  a_rem_below_rate: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == stg_pkg::ST_DIVIDE || state_r == stg_pkg::ST_ROUND |->
    rem_r < rate_eff)
    else $error("divider remainder out of range");

  // emitting with nothing left to emit is a counting slip
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == stg_pkg::ST_EMIT |-> cnt_r != '0)
    else $error("emit state with zero samples left");

  // silent samples carry a zero product
  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_v_r && s1_zero_r |=> prod_r == '0)
    else $error("silent segment produced a nonzero product");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sine tone segment generator
// ----------------------------------------------------------------------------
// Tone segments are queued by the stimulus process and handed to the input
// port by a clocked driver. At each accepted segment an in-bench synthesizer
// (own sine table, phase accumulator and rate / magnitude shadows) works out
// the sample items that the segment must produce. A clocked monitor compares
// every output item with the oldest predicted sample. The run goes through a
// directed opening, two directed register tests and random segments under
// several rate and magnitude settings and four input and output idle patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int DRAIN_CYCLES = 100;
  localparam int RAND_BLOCKS  = 8;
  localparam int BLOCK_SEGS   = 26;

  typedef struct packed {
    logic [stg_pkg::FREQ_W-1:0] freq;
    logic [stg_pkg::LEN_W-1:0]  len;
  } segment_t;

  typedef struct packed {
    logic signed [stg_pkg::SAMPLE_W-1:0] left;
    logic signed [stg_pkg::SAMPLE_W-1:0] right;
    logic                                last;
  } sample_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [stg_pkg::IN_DATA_W-1:0]    in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [stg_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic                             out_tlast;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [stg_pkg::CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [stg_pkg::CFG_DATA_W-1:0]   cfg_data   = '0;

  // synthesizer state mirrored by the bench
  logic signed [stg_pkg::ROM_W-1:0] sine_tbl [stg_pkg::TABLE_LEN];
  logic [stg_pkg::PHASE_BITS-1:0]   phase_acc = '0;
  logic [stg_pkg::PHASE_BITS-1:0]   step_acc  = '0;
  logic [stg_pkg::RATE_W-1:0]       rate_shadow = stg_pkg::RATE_RESET;
  logic [stg_pkg::MAG_W-1:0]        mag_shadow  = stg_pkg::MAG_RESET;

  segment_t seg_queue [$];
  sample_t  sample_q [$];
  segment_t next_seg;
  sample_t  want;

  int segs_queued   = 0;
  int segs_accepted = 0;
  int samples_seen  = 0;
  int err_count     = 0;
  int send_idle_pct = 0;
  int ready_stall_pct = 0;

  // directed opening at the reset settings of 48 kHz and full scale
  segment_t opening_segs [13] = '{
    '{16'd1000,  7'd8},    // plain tone
    '{16'd1000,  7'd0},    // no samples, phase kept
    '{16'd1000,  7'd8},    // phase carries on
    '{16'd0,     7'd4},    // silence, phase cleared
    '{16'd0,     7'd0},    // bare phase reset
    '{16'd65535, 7'd5},    // above the sample rate, aliased step
    '{16'd48000, 7'd3},    // step wraps to zero
    '{16'd24000, 7'd6},    // half the sample rate
    '{16'd1,     7'd2},
    '{16'd12000, 7'd127},  // count saturates to a full segment
    '{16'd3000,  7'd64},
    '{16'd440,   7'd1},
    '{16'd47999, 7'd4}
  };

  int rate_plan [RAND_BLOCKS] = '{192000, 1000, 44100, 262143, 8000, 96000, 48000, 22050};
  int mag_plan  [RAND_BLOCKS] = '{32767, 1, 16384, 12345, 32767, 100, 20000, 1};

  sine_tone_segment_generator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // expected samples of one segment, phase carried between tone segments
  task automatic predict_segment(input logic [stg_pkg::FREQ_W-1:0] freq,
                                 input logic [stg_pkg::LEN_W-1:0] len);
    logic [63:0]                         num;
    logic [63:0]                         quo;
    logic [63:0]                         rem;
    logic [63:0]                         rate;
    logic [stg_pkg::PHASE_BITS-1:0]      ph;
    logic [stg_pkg::MAG_W-1:0]           mag;
    logic [stg_pkg::LEN_W-1:0]           cnt;
    logic [stg_pkg::TABLE_BITS:0]        idx;
    logic signed [stg_pkg::ROM_W-1:0]    ent;
    logic [stg_pkg::ROM_W-1:0]           amag;
    logic [35:0]                         prod;
    logic signed [stg_pkg::SAMPLE_W-1:0] val;
    rate = (rate_shadow == 0) ? 64'd1 : 64'(rate_shadow);
    mag  = (mag_shadow == 0) ? stg_pkg::MAG_W'(1) : mag_shadow;
    cnt  = (len > stg_pkg::MAX_SEGMENT) ? stg_pkg::LEN_W'(stg_pkg::MAX_SEGMENT) : len;
    if (freq == 0) begin
      phase_acc = '0;
      step_acc  = '0;
    end else begin
      // round-to-nearest fraction of a turn per sample
      num = 64'(freq) << stg_pkg::PHASE_BITS;
      quo = num / rate;
      rem = num % rate;
      if (2 * rem >= rate) begin
        quo++;
      end
      step_acc = quo[stg_pkg::PHASE_BITS-1:0];
    end
    ph = phase_acc;
    for (int i = 0; i < cnt; i++) begin
      val = '0;
      if (freq != 0) begin
        // nearest table entry, the top half step wraps to entry zero
        idx = {1'b0, ph[stg_pkg::PHASE_BITS-1 -: stg_pkg::TABLE_BITS]} +
              ph[stg_pkg::PHASE_BITS-stg_pkg::TABLE_BITS-1];
        if (idx >= stg_pkg::TABLE_LEN) begin
          idx = idx - stg_pkg::TABLE_LEN;
        end
        ent  = sine_tbl[idx[stg_pkg::TABLE_BITS-1:0]];
        amag = (ent < 0) ? -ent : ent;
        prod = (amag * mag + 36'd32768) >> 16;
        val  = (ent < 0) ? -stg_pkg::SAMPLE_W'(prod) : stg_pkg::SAMPLE_W'(prod);
        ph   = ph + step_acc;
      end
      sample_q.push_back('{val, val, i == cnt - 1});
    end
    if (freq != 0) begin
      phase_acc = ph;
    end
  endtask

  task automatic queue_segment(input segment_t seg);
    seg_queue.push_back(seg);
    segs_queued++;
  endtask

  // both registers back to back, valid held high across the two items
  task automatic set_tone_regs(input logic [stg_pkg::RATE_W-1:0] rate,
                               input logic [stg_pkg::MAG_W-1:0] mag);
    cfg_valid <= 1'b1;
    cfg_index <= stg_pkg::CFG_SAMPLE_RATE;
    cfg_data  <= rate;
    do @(posedge clk); while (!cfg_ready);
    rate_shadow = rate;
    cfg_index <= stg_pkg::CFG_MAGNITUDE;
    cfg_data  <= stg_pkg::CFG_DATA_W'(mag);
    do @(posedge clk); while (!cfg_ready);
    mag_shadow = mag;
    cfg_valid <= 1'b0;
  endtask

  // every segment taken and every sample seen, then a quiet margin
  task automatic wait_drained();
    do @(posedge clk); while (segs_accepted != segs_queued || sample_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // input driver: one segment per handshake, random gaps per phase
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_segment(in_tdata[stg_pkg::FREQ_W-1:0],
                        in_tdata[stg_pkg::FREQ_W +: stg_pkg::LEN_W]);
        segs_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (seg_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_seg = seg_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= stg_pkg::IN_DATA_W'({next_seg.len, next_seg.freq});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor: compare each sample item with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sample_q.size() == 0) begin
          report_mismatch($sformatf("sample %0d not expected: data %h last %b",
                                    samples_seen, out_tdata, out_tlast));
        end else begin
          want = sample_q.pop_front();
          if (out_tdata[stg_pkg::SAMPLE_W-1:0] !== want.left) begin
            report_mismatch($sformatf("sample %0d left: got %0d want %0d", samples_seen,
                                      $signed(out_tdata[stg_pkg::SAMPLE_W-1:0]),
                                      want.left));
          end
          if (out_tdata[2*stg_pkg::SAMPLE_W-1:stg_pkg::SAMPLE_W] !== want.right) begin
            report_mismatch($sformatf("sample %0d right: got %0d want %0d", samples_seen,
                                      $signed(out_tdata[2*stg_pkg::SAMPLE_W-1:
                                                        stg_pkg::SAMPLE_W]),
                                      want.right));
          end
          if (out_tlast !== want.last) begin
            report_mismatch($sformatf("sample %0d last: got %b want %b", samples_seen,
                                      out_tlast, want.last));
          end
        end
        samples_seen++;
      end
      out_tready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  initial begin : stimulus
    logic [63:0] turns;
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    logic [63:0] acc;
    logic        flip;
    segment_t    seg;
    int          sel;

    // unit sine table: fixed-point taylor series folded into one quadrant
    for (int i = 0; i < stg_pkg::TABLE_LEN; i++) begin
      turns = (64'(i) << 32) / stg_pkg::TABLE_LEN;
      flip  = (turns >= 64'h8000_0000);
      if (flip) begin
        turns = turns - 64'h8000_0000;
      end
      if (turns > 64'h4000_0000) begin
        turns = 64'h8000_0000 - turns;
      end
      ang    = (turns * stg_pkg::TWO_PI_Q30) >> 32;
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      acc    = ang;
      for (int k = 1; k <= 8; k++) begin
        term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) begin
          acc = (acc > term) ? acc - term : 64'd0;
        end else begin
          acc = acc + term;
        end
      end
      acc = (acc + 64'h2000) >> 14;
      sine_tbl[i] = flip ? -stg_pkg::ROM_W'(acc) : stg_pkg::ROM_W'(acc);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_segs[i]) begin
      queue_segment(opening_segs[i]);
    end
    wait_drained();

    // zero registers act as one: step collapses to zero, samples to at most one in magnitude
    set_tone_regs('0, '0);
    queue_segment('{16'd5000, 7'd4});
    queue_segment('{16'd0,    7'd2});
    queue_segment('{16'd1,    7'd3});
    wait_drained();

    // lowest rate, smallest magnitude
    set_tone_regs(stg_pkg::RATE_W'(1000), stg_pkg::MAG_W'(1));
    queue_segment('{16'd500,   7'd4});
    queue_segment('{16'd250,   7'd8});
    queue_segment('{16'd1000,  7'd2});
    queue_segment('{16'd65535, 7'd3});
    wait_drained();

    for (int b = 0; b < RAND_BLOCKS; b++) begin
      case (b % 4)
        0: begin
          send_idle_pct = 0;
          ready_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 45;
          ready_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          ready_stall_pct = 45;
        end
        default: begin
          send_idle_pct = 32;
          ready_stall_pct = 32;
        end
      endcase
      set_tone_regs(stg_pkg::RATE_W'(rate_plan[b]), stg_pkg::MAG_W'(mag_plan[b]));
      for (int n = 0; n < BLOCK_SEGS; n++) begin
        sel = $urandom_range(99);
        if (sel < 8) begin
          seg.freq = '0;
        end else if (sel < 22) begin
          seg.freq = stg_pkg::FREQ_W'($urandom);
        end else begin
          seg.freq = stg_pkg::FREQ_W'($urandom_range(20, 20000));
        end
        sel = $urandom_range(99);
        if (sel < 5) begin
          seg.len = '0;
        end else if (sel < 12) begin
          seg.len = stg_pkg::LEN_W'($urandom_range(stg_pkg::MAX_SEGMENT + 1, 127));
        end else if (sel < 17) begin
          seg.len = stg_pkg::LEN_W'(stg_pkg::MAX_SEGMENT);
        end else begin
          seg.len = stg_pkg::LEN_W'($urandom_range(1, 24));
        end
        queue_segment(seg);
      end
      wait_drained();
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
